@@ hdl/scr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// scr_pkg: shared types and register description table
// Holds the command and result structs, the table of implemented system
// registers and the masked merge function used by the register file.
// ============================================================================
package scr_pkg;

    localparam int TLB_ENTRIES = 64;
    localparam int REG_COUNT   = 54;
    localparam int IDX_W       = $clog2(REG_COUNT);
    localparam int RND_W       = 6;

    localparam logic [RND_W-1:0] RANDOM_TOP = RND_W'(TLB_ENTRIES - 2);

    localparam logic [31:0] CAUSE_TIMER   = 32'h4000_0000;
    localparam logic [31:0] CAUSE_IRQ_HW5 = 32'h0000_8000;
    localparam logic [31:0] RANDOM_HWM    = 32'h8000_003F;

    // Table positions of registers with side effects.
    localparam logic [IDX_W-1:0] IDX_RANDOM  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_WIRED   = IDX_W'(9);
    localparam logic [IDX_W-1:0] IDX_COUNT   = IDX_W'(12);
    localparam logic [IDX_W-1:0] IDX_COMPARE = IDX_W'(16);
    localparam logic [IDX_W-1:0] IDX_STATUS  = IDX_W'(19);
    localparam logic [IDX_W-1:0] IDX_CAUSE   = IDX_W'(23);

    typedef enum logic [2:0] {
        ACT_SW_READ  = 3'd0,
        ACT_SW_WRITE = 3'd1,
        ACT_HW_WRITE = 3'd2,
        ACT_HW_AND   = 3'd3,
        ACT_HW_OR    = 3'd4,
        ACT_RESET    = 3'd5,
        ACT_TICK     = 3'd6,
        ACT_HW_READ  = 3'd7
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [4:0]  register_number;
        logic [2:0]  select;
        logic [31:0] write_data;
    } scr_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        register_missing;
        logic        timer_interrupt;
        logic        kernel_mode;
        logic        user_mode;
        logic        interrupts_enabled;
    } scr_out_t;

    typedef logic [7:0] addr_t;

    // Register address as {number, select}.
    localparam addr_t REG_ADDR [REG_COUNT] = '{
        {5'd0,3'd0}, {5'd1,3'd0}, {5'd2,3'd0}, {5'd3,3'd0}, {5'd4,3'd0},
        {5'd4,3'd1}, {5'd4,3'd2}, {5'd5,3'd0}, {5'd5,3'd1}, {5'd6,3'd0},
        {5'd7,3'd0}, {5'd8,3'd0}, {5'd9,3'd0}, {5'd9,3'd6}, {5'd9,3'd7},
        {5'd10,3'd0}, {5'd11,3'd0}, {5'd11,3'd6}, {5'd11,3'd7}, {5'd12,3'd0},
        {5'd12,3'd1}, {5'd12,3'd2}, {5'd12,3'd3}, {5'd13,3'd0}, {5'd14,3'd0},
        {5'd15,3'd0}, {5'd15,3'd1}, {5'd16,3'd0}, {5'd16,3'd1}, {5'd16,3'd2},
        {5'd16,3'd3}, {5'd16,3'd4}, {5'd16,3'd6}, {5'd16,3'd7}, {5'd17,3'd0},
        {5'd18,3'd0}, {5'd19,3'd0}, {5'd20,3'd0}, {5'd21,3'd0}, {5'd22,3'd0},
        {5'd23,3'd0}, {5'd24,3'd0}, {5'd25,3'd0}, {5'd26,3'd0}, {5'd27,3'd0},
        {5'd27,3'd1}, {5'd27,3'd2}, {5'd27,3'd3}, {5'd28,3'd0}, {5'd28,3'd1},
        {5'd29,3'd0}, {5'd29,3'd1}, {5'd30,3'd0}, {5'd31,3'd0}
    };

    localparam logic [31:0] REG_RST [REG_COUNT] = '{
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h007FFFF0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h00400004,
        32'h4C000000, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h00000400, 32'h80000000, 32'h80008482, 32'h80000000, 32'h80000000,
        32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0
    };

    localparam logic [31:0] REG_HWM [REG_COUNT] = '{
        32'h8000003F, 32'h8000003F, 32'h07FFFFFF, 32'h07FFFFFF, 32'hFFFFFFF0,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1FFFF800, 32'hD800001F, 32'h0000003F,
        32'h0000001F, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0,
        32'hFFFFF8FF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h1E78FF17,
        32'hFF800000, 32'h3C3CF3CF, 32'h0, 32'hB0C0FF7C, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFF3FF, 32'h8000FF8F, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hBFFFFFFF, 32'hFFFFE000, 32'h0, 32'h0, 32'hFFFFFFFF,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'hFFFFFFFF, 32'h0
    };

    localparam logic [31:0] REG_SWM [REG_COUNT] = '{
        32'h0000003F, 32'h0, 32'h07FFFFFF, 32'h07FFFFFF, 32'hFF800000,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1FFFF800, 32'h18000000, 32'h0000003F,
        32'h0000001F, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0,
        32'hFFFFF8FF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h1A78FF17,
        32'h0, 32'h0000F3C0, 32'h0, 32'h00C00300, 32'hFFFFFFFF,
        32'h0, 32'h3FFFF000, 32'h00000007, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'hFFFFFFFF, 32'h0
    };

    // Masked merge of a value into an old register value.
    function automatic logic [31:0] merge(input logic [31:0] old_val,
                                          input logic [31:0] val,
                                          input logic [31:0] mask);
        return (old_val & ~mask) | (val & mask);
    endfunction

endpackage

@@ hdl/system_coprocessor_registers.sv @@
`timescale 1ns / 1ps
// ============================================================================
// system_coprocessor_registers: system control register file
// Command register, register file update and result register.
// ============================================================================
// Usage:
//   A command (action, register number, select, write data) is transferred
//   at a rising edge with start high and busy low. busy is always low, so a
//   command may be issued in every cycle.
//   The command is registered, then in the following cycle the register
//   file is read, updated and the result is captured. done is high for one
//   cycle with the result, after the command register and the result register.
//   Throughput is one command per cycle, set by the single
//   read-modify-write pass over the register flops.
//   Back-to-back commands see each other's updates in order.
//   Reset loads every register with its reset value, sets the Random
//   counter to the top entry and drops any command in flight.
//   The receiver cannot stall: each result is valid for exactly one cycle.
// ============================================================================
module system_coprocessor_registers
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  scr_pkg::scr_in_t  cmd,
    output logic              done,
    output scr_pkg::scr_out_t result
);

    logic              cmd_valid_reg;
    scr_pkg::scr_in_t  cmd_reg;
    scr_pkg::scr_out_t res_next;
    logic              done_reg;
    scr_pkg::scr_out_t result_reg;

    assign busy = 1'b0;

    // Command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
    end

    scr_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid_reg),
        .cmd       (cmd_reg),
        .res       (res_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            result_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/scr_regfile.sv @@
`timescale 1ns / 1ps
// ============================================================================
// scr_regfile: system register storage and single-pass update
// Decodes one registered command, updates the register flops and the
// Random counter, and forms the result fields combinationally.
// ============================================================================
module scr_regfile
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  scr_pkg::scr_in_t cmd,
    output scr_pkg::scr_out_t res
);

    logic [31:0] regs_reg  [scr_pkg::REG_COUNT];
    logic [31:0] regs_next [scr_pkg::REG_COUNT];
    logic [scr_pkg::RND_W-1:0] rnd_reg;
    logic [scr_pkg::RND_W-1:0] rnd_next;

    logic                      hit;
    logic [scr_pkg::IDX_W-1:0] idx;
    logic [31:0]               cur;
    logic [31:0]               count_inc;
    logic [scr_pkg::RND_W-1:0] rnd_step;
    logic [31:0]               rnd_merged;
    logic                      is_random;
    logic [31:0]               base;
    logic [31:0]               status;

    // Address lookup against the register table.
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = 0; i < scr_pkg::REG_COUNT; i++)
        begin
            if (scr_pkg::REG_ADDR[i] == {cmd.register_number, cmd.select})
            begin
                hit = 1'b1;
                idx = scr_pkg::IDX_W'(i);
            end
        end
    end

    // Random counter step and its merged register value.
    always_comb
    begin
        if (rnd_reg <= regs_reg[scr_pkg::IDX_WIRED][scr_pkg::RND_W-1:0]
            || rnd_reg > scr_pkg::RANDOM_TOP)
        begin
            rnd_step = scr_pkg::RANDOM_TOP;
        end
        else
        begin
            rnd_step = rnd_reg - scr_pkg::RND_W'(1);
        end
        rnd_merged = scr_pkg::merge(regs_reg[scr_pkg::IDX_RANDOM],
                                    32'(rnd_step), scr_pkg::RANDOM_HWM);
    end

    assign cur       = regs_reg[idx];
    assign is_random = (idx == scr_pkg::IDX_RANDOM);
    assign base      = is_random ? rnd_merged : cur;
    assign count_inc = regs_reg[scr_pkg::IDX_COUNT] + 32'd1;

    // Next state and result for the command.
    always_comb
    begin
        regs_next            = regs_reg;
        rnd_next             = rnd_reg;
        res.read_data        = '0;
        res.register_missing = 1'b0;
        res.timer_interrupt  = 1'b0;
        if (cmd_valid)
        begin
            if (cmd.action == scr_pkg::ACT_TICK)
            begin
                regs_next[scr_pkg::IDX_COUNT] = count_inc;
                if (regs_reg[scr_pkg::IDX_COMPARE] != 32'd0
                    && count_inc == regs_reg[scr_pkg::IDX_COMPARE])
                begin
                    regs_next[scr_pkg::IDX_CAUSE] =
                        regs_reg[scr_pkg::IDX_CAUSE] | scr_pkg::CAUSE_TIMER;
                    res.timer_interrupt = 1'b1;
                end
            end
            else if (!hit)
            begin
                res.register_missing = 1'b1;
            end
            else
            begin
                case (cmd.action)
                    scr_pkg::ACT_SW_READ:
                    begin
                        if (is_random)
                        begin
                            rnd_next = rnd_step;
                            regs_next[idx] = rnd_merged;
                        end
                        res.read_data = base;
                    end
                    scr_pkg::ACT_SW_WRITE:
                    begin
                        if (is_random)
                        begin
                            rnd_next = rnd_step;
                        end
                        // A Compare write acknowledges a pending timer interrupt.
                        if (idx == scr_pkg::IDX_COMPARE
                            && (regs_reg[scr_pkg::IDX_CAUSE] & scr_pkg::CAUSE_TIMER) != 32'd0)
                        begin
                            regs_next[scr_pkg::IDX_CAUSE] = regs_reg[scr_pkg::IDX_CAUSE]
                                & ~(scr_pkg::CAUSE_TIMER | scr_pkg::CAUSE_IRQ_HW5);
                        end
                        regs_next[idx] = scr_pkg::merge(base, cmd.write_data,
                                                        scr_pkg::REG_SWM[idx]);
                    end
                    scr_pkg::ACT_HW_WRITE:
                    begin
                        regs_next[idx] = scr_pkg::merge(cur, cmd.write_data,
                                                        scr_pkg::REG_HWM[idx]);
                    end
                    scr_pkg::ACT_HW_AND:
                    begin
                        regs_next[idx] = cur & (cmd.write_data | ~scr_pkg::REG_HWM[idx]);
                    end
                    scr_pkg::ACT_HW_OR:
                    begin
                        regs_next[idx] = cur | (cmd.write_data & scr_pkg::REG_HWM[idx]);
                    end
                    scr_pkg::ACT_RESET:
                    begin
                        regs_next[idx] = scr_pkg::REG_RST[idx];
                    end
                    default:
                    begin
                        res.read_data = cur;
                    end
                endcase
            end
        end

        // Mode decode from Status after the update.
        status = regs_next[scr_pkg::IDX_STATUS];
        res.kernel_mode = (status[4:3] == 2'b00) || status[1] || status[2];
        res.user_mode   = (status[4:3] == 2'b10) && (status[2:1] == 2'b00);
        res.interrupts_enabled = status[0];
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scr_pkg::REG_COUNT; i++)
            begin
                regs_reg[i] <= scr_pkg::REG_RST[i];
            end
            rnd_reg <= scr_pkg::RANDOM_TOP;
        end
        else
        begin
            regs_reg <= regs_next;
            rnd_reg  <= rnd_next;
        end
    end

endmodule
